// ===== src/regular_polygon_vertex_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the regular polygon vertex generator
// Short forms for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_MACROS_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define RPVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rpvg assertion failed");

// next-cycle implication
`define RPVG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rpvg assertion failed");

`endif

// ===== src/rpvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rpvg_pkg
// Constants, tables and arithmetic helpers of the polygon vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpvg_pkg;

  // default parameter values
  localparam int MaxCornersDef  = 16;
  localparam int CordicStepsDef = 16;
  // results per item are capped by the index field
  localparam int ResultLimit    = 16;

  // cordic datapath: q2.30 with headroom
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] a;
    unique case (k)
      5'd0:    a = 30'h20000000;
      5'd1:    a = 30'h12E4051E;
      5'd2:    a = 30'h09FB385B;
      5'd3:    a = 30'h051111D4;
      5'd4:    a = 30'h028B0D43;
      5'd5:    a = 30'h0145D7E1;
      5'd6:    a = 30'h00A2F61E;
      5'd7:    a = 30'h00517C55;
      5'd8:    a = 30'h0028BE53;
      5'd9:    a = 30'h00145F2F;
      5'd10:   a = 30'h000A2F98;
      5'd11:   a = 30'h000517CC;
      5'd12:   a = 30'h00028BE6;
      5'd13:   a = 30'h000145F3;
      5'd14:   a = 30'h0000A2FA;
      5'd15:   a = 30'h0000517D;
      5'd16:   a = 30'h000028BE;
      5'd17:   a = 30'h0000145F;
      5'd18:   a = 30'h00000A30;
      5'd19:   a = 30'h00000518;
      5'd20:   a = 30'h0000028C;
      5'd21:   a = 30'h00000146;
      5'd22:   a = 30'h000000A3;
      5'd23:   a = 30'h00000051;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

  // whole part of a full turn split into count steps (mod one turn)
  function automatic logic [15:0] turn_step(input logic [4:0] count);
    logic [15:0] s;
    unique case (count)
      5'd2:    s = 16'd32768;
      5'd3:    s = 16'd21845;
      5'd4:    s = 16'd16384;
      5'd5:    s = 16'd13107;
      5'd6:    s = 16'd10922;
      5'd7:    s = 16'd9362;
      5'd8:    s = 16'd8192;
      5'd9:    s = 16'd7281;
      5'd10:   s = 16'd6553;
      5'd11:   s = 16'd5957;
      5'd12:   s = 16'd5461;
      5'd13:   s = 16'd5041;
      5'd14:   s = 16'd4681;
      5'd15:   s = 16'd4369;
      5'd16:   s = 16'd4096;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

  // remainder of a full turn split into count steps
  function automatic logic [3:0] turn_rem(input logic [4:0] count);
    logic [3:0] r;
    unique case (count)
      5'd3, 5'd5, 5'd15: r = 4'd1;
      5'd7, 5'd14:       r = 4'd2;
      5'd13:             r = 4'd3;
      5'd6, 5'd12:       r = 4'd4;
      5'd10:             r = 4'd6;
      5'd9:              r = 4'd7;
      5'd11:             r = 4'd9;
      default:           r = 4'd0;
    endcase
    return r;
  endfunction

  // round q2.30 to q1.15 and clamp to +/-32767
  function automatic logic signed [15:0] to_q15(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] w;
    logic signed [CordicW-16:0] r;
    logic signed [15:0]         q;
    w = v + CordicW'(16384);
    r = $signed(w[CordicW-1:15]);
    if (r > (CordicW-15)'(32767)) begin
      q = 16'sd32767;
    end else if (r < -(CordicW-15)'(32767)) begin
      q = -16'sd32767;
    end else begin
      q = 16'(r);
    end
    return q;
  endfunction

  // centre plus scaled product, divided by 2^15 toward zero
  function automatic logic signed [16:0] coord_trunc(input logic signed [15:0] centre,
                                                     input logic signed [31:0] prod);
    logic signed [31:0] sum;
    logic signed [31:0] biased;
    sum    = 32'($signed({centre, 15'd0})) + prod;
    biased = sum + (sum[31] ? 32'sd32767 : 32'sd0);
    return $signed(biased[31:15]);
  endfunction

endpackage

// ===== src/regular_polygon_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator
// Corner coordinates of a regular polygon from a shared iterative cordic.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  command   | in        | start high, busy low    | centre, radius, angle, count
//  result    | out       | result_strobe_o, 1 cyc  | corner x/y, index, flags
//
//  A refused count gives its single result in the cycle after the command.
//  An accepted polygon runs each corner through load, rotate (one cordic
//  iteration per cycle), fold, multiply and two multiply/add states,
//  all on one rotator and one 16x16 multiplier.
//  Reset is asynchronous and leaves the block idle with no strobe.
//  Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "regular_polygon_vertex_generator_macros.svh"

module regular_polygon_vertex_generator
  import rpvg_pkg::*;
#(
  parameter int MAX_CORNERS  = MaxCornersDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic        [14:0] circum_radius_i,
  input  logic        [15:0] start_angle_i,
  input  logic        [4:0]  vertex_count_i,
  output logic               result_strobe_o,
  output logic signed [16:0] corner_x_o,
  output logic signed [16:0] corner_y_o,
  output logic        [3:0]  corner_index_o,
  output logic               last_corner_o,
  output logic               rejected_o
);

  localparam int Limit = (MAX_CORNERS < ResultLimit) ? MAX_CORNERS : ResultLimit;
  localparam int KW    = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROT,
    S_FOLD,
    S_MUL_X,
    S_ADD_X,
    S_ADD_Y
  } state_e;

  state_e                     state_q, state_d;
  logic signed [15:0]         cx_q, cx_d, cy_q, cy_d;
  logic        [14:0]         radius_q, radius_d;
  logic        [4:0]          count_q, count_d;
  logic        [15:0]         phase_q, phase_d;
  logic        [4:0]          rem_acc_q, rem_acc_d;
  logic        [3:0]          idx_q, idx_d;
  logic        [1:0]          quad_q, quad_d;
  logic        [KW-1:0]       k_q, k_d;
  logic signed [CordicW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [15:0]         cos_q, cos_d, sin_q, sin_d;
  logic signed [31:0]         prod_q, prod_d;
  logic signed [16:0]         px_q, px_d;
  logic                       strobe_q, strobe_d;
  logic signed [16:0]         ox_q, ox_d, oy_q, oy_d;
  logic        [3:0]          oidx_q, oidx_d;
  logic                       olast_q, olast_d, orej_q, orej_d;

  // shared rotator terms
  logic signed [CordicW-1:0]  xs, ys, atan_k;
  // shared multiplier
  logic signed [15:0]         mul_b;
  logic signed [31:0]         mul_p;
  // fold terms
  logic signed [15:0]         c15, s15;
  // angle step terms
  logic        [4:0]          rem_sum;
  logic                       carry;
  logic                       last_c;

  assign xs     = x_q >>> k_q;
  assign ys     = y_q >>> k_q;
  assign atan_k = CordicW'(atan_turn(5'(k_q)));

  assign mul_b  = (state_q == S_MUL_X) ? cos_q : sin_q;
  assign mul_p  = 32'($signed({1'b0, radius_q}) * mul_b);

  assign c15    = to_q15(x_q);
  assign s15    = to_q15(y_q);

  assign rem_sum = rem_acc_q + 5'(turn_rem(count_q));
  assign carry   = (rem_sum >= count_q);
  assign last_c  = (idx_q == 4'(count_q - 5'd1));

  assign busy = (state_q != S_IDLE);

  // sequencer and datapath next state
  always_comb begin
    state_d   = state_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    radius_d  = radius_q;
    count_d   = count_q;
    phase_d   = phase_q;
    rem_acc_d = rem_acc_q;
    idx_d     = idx_q;
    quad_d    = quad_q;
    k_d       = k_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    cos_d     = cos_q;
    sin_d     = sin_q;
    prod_d    = prod_q;
    px_d      = px_q;
    strobe_d  = 1'b0;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oidx_d    = oidx_q;
    olast_d   = olast_q;
    orej_d    = orej_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (vertex_count_i == 5'd0 || vertex_count_i > 5'(Limit)) begin
            // refused count: single flagged beat
            strobe_d = 1'b1;
            ox_d     = '0;
            oy_d     = '0;
            oidx_d   = '0;
            olast_d  = 1'b1;
            orej_d   = 1'b1;
          end else begin
            cx_d      = center_x_i;
            cy_d      = center_y_i;
            radius_d  = circum_radius_i;
            count_d   = vertex_count_i;
            phase_d   = start_angle_i;
            rem_acc_d = '0;
            idx_d     = '0;
            state_d   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // quadrant fold and rotator seed
        quad_d  = phase_q[15:14];
        x_d     = CordicGain;
        y_d     = '0;
        z_d     = CordicW'({phase_q[13:0], 16'd0});
        k_d     = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        // one micro-rotation per cycle
        if (!z_q[CordicW-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_k;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_k;
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(CORDIC_STEPS - 1)) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // back to the full circle
        unique case (quad_q)
          2'd0: begin cos_d = c15;  sin_d = s15;  end
          2'd1: begin cos_d = -s15; sin_d = c15;  end
          2'd2: begin cos_d = -c15; sin_d = -s15; end
          default: begin cos_d = s15; sin_d = -c15; end
        endcase
        state_d = S_MUL_X;
      end
      S_MUL_X: begin
        prod_d  = mul_p;
        state_d = S_ADD_X;
      end
      S_ADD_X: begin
        px_d    = coord_trunc(cx_q, prod_q);
        prod_d  = mul_p;
        state_d = S_ADD_Y;
      end
      S_ADD_Y: begin
        // corner beat, then step the angle
        strobe_d  = 1'b1;
        ox_d      = px_q;
        oy_d      = coord_trunc(cy_q, prod_q);
        oidx_d    = idx_q;
        olast_d   = last_c;
        orej_d    = 1'b0;
        rem_acc_d = carry ? (rem_sum - count_q) : rem_sum;
        phase_d   = phase_q + turn_step(count_q) + 16'(carry);
        idx_d     = idx_q + 4'd1;
        state_d   = last_c ? S_IDLE : S_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      strobe_q  <= 1'b0;
      cx_q      <= '0;
      cy_q      <= '0;
      radius_q  <= '0;
      count_q   <= '0;
      phase_q   <= '0;
      rem_acc_q <= '0;
      idx_q     <= '0;
      quad_q    <= '0;
      k_q       <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      cos_q     <= '0;
      sin_q     <= '0;
      prod_q    <= '0;
      px_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      oidx_q    <= '0;
      olast_q   <= 1'b0;
      orej_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      strobe_q  <= strobe_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      radius_q  <= radius_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      rem_acc_q <= rem_acc_d;
      idx_q     <= idx_d;
      quad_q    <= quad_d;
      k_q       <= k_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      cos_q     <= cos_d;
      sin_q     <= sin_d;
      prod_q    <= prod_d;
      px_q      <= px_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      oidx_q    <= oidx_d;
      olast_q   <= olast_d;
      orej_q    <= orej_d;
    end
  end

  assign result_strobe_o = strobe_q;
  assign corner_x_o      = ox_q;
  assign corner_y_o      = oy_q;
  assign corner_index_o  = oidx_q;
  assign last_corner_o   = olast_q;
  assign rejected_o      = orej_q;

  // checks
  `RPVG_ASSERT_IMP(a_rej_single, clk_i, rst_ni, result_strobe_o && rejected_o, last_corner_o && corner_index_o == 4'd0)
  `RPVG_ASSERT_NXT(a_accept_acts, clk_i, rst_ni, start && !busy, busy || (result_strobe_o && rejected_o))
  `RPVG_ASSERT_IMP(a_more_corners, clk_i, rst_ni, result_strobe_o && !last_corner_o, busy)
  `RPVG_ASSERT_IMP(a_index_range, clk_i, rst_ni, result_strobe_o && !rejected_o, corner_index_o <= 4'(count_q - 5'd1))

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives polygon commands into the corner generator and checks every corner
// beat against a local cordic predictor of sine, cosine and the truncated
// coordinates, with random sender gaps and pauses that drain the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int     ClkPeriod     = 10;
  localparam int     CornerLimit   = 16;
  localparam int     CordicSteps   = 16;
  localparam longint CordicGainQ30 = 652032874;
  localparam int     CycleLimit    = 2000000;
  localparam int     SettleCycles  = 400;
  localparam int     RandomPerPass = 120;

  // arctangent of 2^-k in units of 2^-32 turn
  localparam longint AtanTurn [0:15] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic        [3:0]  index;
    logic               last;
    logic               rejected;
  } corner_t;

  // predicted corners per polygon, checked in order of arrival
  class corner_scoreboard;
    corner_t pending_corners[$];
    int      mismatches = 0;

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function longint round_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return r;
    endfunction

    // rotation-mode cordic on the folded angle, then unfold by quadrant
    function void unit_vector(input logic [15:0] phase, output longint cos_q15,
                              output longint sin_q15);
      longint x, y, z, xs, ys, c, s;
      x = CordicGainQ30;
      y = 0;
      z = longint'({phase[13:0], 16'b0});
      for (int k = 0; k < CordicSteps; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - AtanTurn[k];
        end else begin
          x = x + ys; y = y - xs; z = z + AtanTurn[k];
        end
      end
      c = round_q15(x);
      s = round_q15(y);
      case (phase[15:14])
        2'd0: begin cos_q15 = c;  sin_q15 = s;  end
        2'd1: begin cos_q15 = -s; sin_q15 = c;  end
        2'd2: begin cos_q15 = -c; sin_q15 = -s; end
        default: begin cos_q15 = s; sin_q15 = -c; end
      endcase
    endfunction

    // centre plus radius times trig, divided by 2^15 toward zero
    function longint corner_coord(longint centre, longint radius, longint trig);
      longint sum;
      sum = centre * 32768 + radius * trig;
      if (sum >= 0) return sum >>> 15;
      return -((-sum) >>> 15);
    endfunction

    function void note_polygon(logic signed [15:0] cx, logic signed [15:0] cy,
                               logic [14:0] radius, logic [15:0] angle,
                               logic [4:0] count);
      corner_t     c;
      logic [15:0] phase;
      longint      cs, sn;
      if (count == 0 || count > CornerLimit) begin
        c = '{x: '0, y: '0, index: '0, last: 1'b1, rejected: 1'b1};
        pending_corners = {pending_corners, c};
      end else begin
        for (int i = 0; i < int'(count); i++) begin
          phase = angle + 16'((i * 65536) / int'(count));
          unit_vector(phase, cs, sn);
          c.x        = 17'(corner_coord(longint'(cx), longint'(radius), cs));
          c.y        = 17'(corner_coord(longint'(cy), longint'(radius), sn));
          c.index    = 4'(i);
          c.last     = (i + 1 == int'(count));
          c.rejected = 1'b0;
          pending_corners = {pending_corners, c};
        end
      end
    endfunction

    task check_corner(corner_t seen);
      corner_t want;
      if (pending_corners.size() == 0) begin
        report_mismatch($sformatf("unexpected corner beat, index %0d", seen.index));
      end else begin
        want = pending_corners.pop_front();
        if (seen.x !== want.x)
          report_mismatch($sformatf("corner_x %0d, expected %0d", seen.x, want.x));
        if (seen.y !== want.y)
          report_mismatch($sformatf("corner_y %0d, expected %0d", seen.y, want.y));
        if (seen.index !== want.index)
          report_mismatch($sformatf("corner_index %0d, expected %0d",
                                    seen.index, want.index));
        if (seen.last !== want.last)
          report_mismatch($sformatf("last_corner %0b, expected %0b on index %0d",
                                    seen.last, want.last, want.index));
        if (seen.rejected !== want.rejected)
          report_mismatch($sformatf("rejected %0b, expected %0b",
                                    seen.rejected, want.rejected));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] center_x_i;
  logic signed [15:0] center_y_i;
  logic        [14:0] circum_radius_i;
  logic        [15:0] start_angle_i;
  logic        [4:0]  vertex_count_i;
  logic               result_strobe_o;
  logic signed [16:0] corner_x_o;
  logic signed [16:0] corner_y_o;
  logic        [3:0]  corner_index_o;
  logic               last_corner_o;
  logic               rejected_o;

  corner_scoreboard sb = new;
  int               sender_idle_pct = 21;
  int               cycle_count = 0;

  regular_polygon_vertex_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .circum_radius_i (circum_radius_i),
    .start_angle_i   (start_angle_i),
    .vertex_count_i  (vertex_count_i),
    .result_strobe_o (result_strobe_o),
    .corner_x_o      (corner_x_o),
    .corner_y_o      (corner_y_o),
    .corner_index_o  (corner_index_o),
    .last_corner_o   (last_corner_o),
    .rejected_o      (rejected_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // corner beats, sampled at the edge that accepts them
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) begin
      sb.check_corner('{x: corner_x_o, y: corner_y_o, index: corner_index_o,
                        last: last_corner_o, rejected: rejected_o});
    end
  end

  // one command beat, after a random gap, held until the block takes it
  task automatic send_polygon(input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic [14:0] radius, input logic [15:0] angle,
                              input logic [4:0] count);
    int gap;
    gap = 0;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) gap++;
    // occasional long pause so the next command lands at any point of a polygon
    if (sender_idle_pct != 0 && $urandom_range(99) < 4) gap += $urandom_range(1, 350);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start           = 1'b1;
    center_x_i      = cx;
    center_y_i      = cy;
    circum_radius_i = radius;
    start_angle_i   = angle;
    vertex_count_i  = count;
    do @(posedge clk_i); while (busy);
    sb.note_polygon(cx, cy, radius, angle, count);
  endtask

  // hold off until every predicted corner has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending_corners.size() != 0) @(posedge clk_i);
  endtask

  // mostly valid counts, some refused ones, extremes now and then
  task automatic send_random_polygon();
    logic signed [15:0] cx, cy;
    logic        [14:0] radius;
    logic        [4:0]  count;
    cx     = 16'($urandom);
    cy     = 16'($urandom);
    radius = 15'($urandom);
    if ($urandom_range(99) < 10) cx = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(99) < 10) cy = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(99) < 15) radius = $urandom_range(1) ? 15'h7FFF : 15'h0;
    if ($urandom_range(99) < 12) begin
      count = $urandom_range(1) ? 5'd0 : 5'($urandom_range(CornerLimit + 1, 31));
    end else begin
      count = 5'($urandom_range(1, CornerLimit));
    end
    send_polygon(cx, cy, radius, 16'($urandom), count);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    center_x_i      = '0;
    center_y_i      = '0;
    circum_radius_i = '0;
    start_angle_i   = '0;
    vertex_count_i  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, quadrant boundaries, refused counts
    send_polygon(16'sd0, 16'sd0, 15'd0, 16'h0000, 5'd1);
    send_polygon(16'sd0, 16'sd0, 15'd32767, 16'h0000, 5'd4);
    send_polygon(16'sd32767, 16'sd32767, 15'd32767, 16'h2000, 5'd16);
    send_polygon(-16'sd32768, -16'sd32768, 15'd32767, 16'h1234, 5'd16);
    send_polygon(-16'sd32768, 16'sd32767, 15'd32767, 16'hFFFF, 5'd3);
    send_polygon(16'sd100, -16'sd100, 15'd1000, 16'h4000, 5'd2);
    send_polygon(16'sd0, 16'sd0, 15'd32767, 16'h8000, 5'd5);
    send_polygon(16'sd0, 16'sd0, 15'd32767, 16'hC000, 5'd7);
    send_polygon(16'sd5, 16'sd5, 15'd77, 16'h0100, 5'd0);
    send_polygon(16'sd5, 16'sd5, 15'd77, 16'h0100, 5'd17);
    send_polygon(-16'sd1, 16'sd1, 15'd32767, 16'hFFFF, 5'd31);
    send_polygon(-16'sd1, -16'sd1, 15'd1, 16'hFFFF, 5'd16);
    send_polygon(16'sd12345, -16'sd23456, 15'd20000, 16'h3FFF, 5'd9);
    send_polygon(16'sd0, 16'sd0, 15'd32767, 16'h0001, 5'd11);
    send_polygon(16'sh7FFF, -16'sd1, 15'h5555, 16'hAAAA, 5'd13);
    send_polygon(-16'sd12, 16'sd7, 15'd32767, 16'h1000, 5'd15);
    send_polygon(16'sd0, -16'sd32768, 15'h2AAA, 16'h5555, 5'd6);
    send_polygon(-16'sd32768, 16'sd0, 15'd32767, 16'hBFFF, 5'd8);
    send_polygon(16'sd1, 16'sd1, 15'd3, 16'h7FFF, 5'd10);
    send_polygon(16'sd32767, -16'sd32768, 15'd16384, 16'hC001, 5'd12);
    send_polygon(16'sd0, 16'sd0, 15'd32767, 16'h6000, 5'd14);

    // random passes: sender gaps at 21 %, 64 %, then none
    for (int pass = 0; pass < 3; pass++) begin
      sender_idle_pct = (pass == 0) ? 21 : (pass == 1) ? 64 : 0;
      for (int n = 0; n < RandomPerPass; n++) begin
        if (n % 40 == 39) wait_drained();
        send_random_polygon();
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== regular_polygon_vertex_generator.f =====
+incdir+src
src/rpvg_pkg.sv
src/regular_polygon_vertex_generator.sv
verif/testbench.sv
